// ===== hdl/r16icd_pkg.sv =====
// ----------------------------------------------------------------------------
// RISC16 instruction class decoder package
// Class code type, named class codes and the per-group decode tables.
// ----------------------------------------------------------------------------
package r16icd_pkg;

	localparam int WORD_W  = 16;
	localparam int CLASS_W = 8;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [CLASS_W-1:0] class_t;

	// Top-nibble instruction groups.
	typedef enum logic [3:0] {
		GRP_0 = 4'h0, GRP_1 = 4'h1, GRP_2 = 4'h2, GRP_3 = 4'h3,
		GRP_4 = 4'h4, GRP_5 = 4'h5, GRP_6 = 4'h6, GRP_7 = 4'h7,
		GRP_8 = 4'h8, GRP_9 = 4'h9, GRP_A = 4'hA, GRP_B = 4'hB,
		GRP_C = 4'hC, GRP_D = 4'hD, GRP_E = 4'hE, GRP_F = 4'hF
	} group_t;

	// Special and branch-type class codes.
	localparam class_t CLS_ILLEGAL      = 8'd0;
	localparam class_t CLS_ILLEGAL_SLOT = 8'd1;
	localparam class_t CLS_CLRT         = 8'd2;
	localparam class_t CLS_NOP          = 8'd3;
	localparam class_t CLS_RTS          = 8'd4;
	localparam class_t CLS_SETT         = 8'd5;
	localparam class_t CLS_DIV0U        = 8'd6;
	localparam class_t CLS_SLEEP        = 8'd7;
	localparam class_t CLS_CLRMAC       = 8'd8;
	localparam class_t CLS_RTE          = 8'd9;
	localparam class_t CLS_STC_SR       = 8'd10;
	localparam class_t CLS_BSRF         = 8'd11;
	localparam class_t CLS_STS_MACH     = 8'd12;
	localparam class_t CLS_STC_GBR      = 8'd13;
	localparam class_t CLS_STS_MACL     = 8'd14;
	localparam class_t CLS_STC_VBR      = 8'd15;
	localparam class_t CLS_BRAF         = 8'd16;
	localparam class_t CLS_MOVT         = 8'd17;
	localparam class_t CLS_STS_PR       = 8'd18;
	localparam class_t CLS_MOVL_DISP_ST = 8'd27;
	localparam class_t CLS_MACW         = 8'd57;
	localparam class_t CLS_JSR          = 8'd69;
	localparam class_t CLS_JMP          = 8'd94;
	localparam class_t CLS_MOVL_DISP_LD = 8'd96;
	localparam class_t CLS_GRP6_BASE    = 8'd97;
	localparam class_t CLS_ADD_IMM      = 8'd113;
	localparam class_t CLS_BT           = 8'd119;
	localparam class_t CLS_BF           = 8'd120;
	localparam class_t CLS_BTS          = 8'd121;
	localparam class_t CLS_BFS          = 8'd122;
	localparam class_t CLS_MOVW_IMM     = 8'd123;
	localparam class_t CLS_BRA          = 8'd124;
	localparam class_t CLS_BSR          = 8'd125;
	localparam class_t CLS_GRPC_BASE    = 8'd126;
	localparam class_t CLS_TRAPA        = 8'd129;
	localparam class_t CLS_MOVL_IMM     = 8'd142;
	localparam class_t CLS_MOV_IMM      = 8'd143;
	localparam class_t CLS_MAX          = CLS_MOV_IMM;

	// Group 4 low-byte forms cover low bytes below this bound.
	localparam int GRP4_BYTES = 48;

	localparam class_t GRP0_NIB [16] = '{
		8'd0,  8'd0,  8'd0,  8'd0,  8'd19, 8'd20, 8'd21, 8'd22,
		8'd0,  8'd0,  8'd0,  8'd0,  8'd23, 8'd24, 8'd25, 8'd26
	};
	localparam class_t GRP2_NIB [16] = '{
		8'd28, 8'd29, 8'd30, 8'd0,  8'd31, 8'd32, 8'd33, 8'd34,
		8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42
	};
	localparam class_t GRP3_NIB [16] = '{
		8'd43, 8'd0,  8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49,
		8'd50, 8'd0,  8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56
	};
	localparam class_t GRP4_BYTE [GRP4_BYTES] = '{
		8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd65,
		8'd66, 8'd67, 8'd68, 8'd69, 8'd0,  8'd0,  8'd70, 8'd0,
		8'd71, 8'd72, 8'd73, 8'd74, 8'd0,  8'd75, 8'd76, 8'd77,
		8'd78, 8'd79, 8'd80, 8'd81, 8'd0,  8'd0,  8'd82, 8'd0,
		8'd83, 8'd84, 8'd85, 8'd86, 8'd87, 8'd88, 8'd89, 8'd90,
		8'd91, 8'd92, 8'd93, 8'd94, 8'd0,  8'd0,  8'd95, 8'd0
	};
	localparam class_t GRP8_MID [16] = '{
		8'd114, 8'd115, 8'd0,   8'd0,   8'd116, 8'd117, 8'd0,   8'd0,
		8'd118, 8'd119, 8'd0,   8'd120, 8'd0,   8'd121, 8'd0,   8'd122
	};

	// Branches, jumps, returns and TRAPA may not sit in a delay slot.
	function automatic logic is_slot_illegal(input class_t cls);
		logic hit;
		begin
			hit = (cls == CLS_RTS) || (cls == CLS_RTE) || (cls == CLS_BSRF) ||
				(cls == CLS_BRAF) || (cls == CLS_JSR) || (cls == CLS_JMP) ||
				(cls == CLS_BT) || (cls == CLS_BF) || (cls == CLS_BTS) ||
				(cls == CLS_BFS) || (cls == CLS_BRA) || (cls == CLS_BSR) ||
				(cls == CLS_TRAPA);
			return hit;
		end
	endfunction

endpackage

// ===== hdl/r16icd_decode.sv =====
// ----------------------------------------------------------------------------
// RISC16 instruction class decode logic
// Combinational classification of one instruction word, with slot filtering.
// ----------------------------------------------------------------------------
module r16icd_decode (
	input  r16icd_pkg::word_t  word,
	input  logic               slot,
	output r16icd_pkg::class_t cls
);
	import r16icd_pkg::*;

	logic [3:0] nib;
	logic [3:0] mid;
	logic [7:0] lb;
	class_t     grp0_cls;
	class_t     raw_cls;

	assign nib = word[3:0];
	assign mid = word[11:8];
	assign lb  = word[7:0];

	// Group 0: whole-word forms first, then low-byte forms, then low nibble.
	always_comb begin
		unique case (word)
			16'h0008: grp0_cls = CLS_CLRT;
			16'h0009: grp0_cls = CLS_NOP;
			16'h000B: grp0_cls = CLS_RTS;
			16'h0018: grp0_cls = CLS_SETT;
			16'h0019: grp0_cls = CLS_DIV0U;
			16'h001B: grp0_cls = CLS_SLEEP;
			16'h0028: grp0_cls = CLS_CLRMAC;
			16'h002B: grp0_cls = CLS_RTE;
			default: begin
				unique case (lb)
					8'h02:   grp0_cls = CLS_STC_SR;
					8'h03:   grp0_cls = CLS_BSRF;
					8'h0A:   grp0_cls = CLS_STS_MACH;
					8'h12:   grp0_cls = CLS_STC_GBR;
					8'h1A:   grp0_cls = CLS_STS_MACL;
					8'h22:   grp0_cls = CLS_STC_VBR;
					8'h23:   grp0_cls = CLS_BRAF;
					8'h29:   grp0_cls = CLS_MOVT;
					8'h2A:   grp0_cls = CLS_STS_PR;
					default: grp0_cls = GRP0_NIB[nib];
				endcase
			end
		endcase
	end

	always_comb begin
		unique case (group_t'(word[15:12]))
			GRP_0: raw_cls = grp0_cls;
			GRP_1: raw_cls = CLS_MOVL_DISP_ST;
			GRP_2: raw_cls = GRP2_NIB[nib];
			GRP_3: raw_cls = GRP3_NIB[nib];
			GRP_4: begin
				if (nib == 4'hF) begin
					raw_cls = CLS_MACW;
				end else if (lb < 8'(GRP4_BYTES)) begin
					raw_cls = GRP4_BYTE[lb[5:0]];
				end else begin
					raw_cls = CLS_ILLEGAL;
				end
			end
			GRP_5: raw_cls = CLS_MOVL_DISP_LD;
			GRP_6: raw_cls = CLS_GRP6_BASE + class_t'(nib);
			GRP_7: raw_cls = CLS_ADD_IMM;
			GRP_8: raw_cls = GRP8_MID[mid];
			GRP_9: raw_cls = CLS_MOVW_IMM;
			GRP_A: raw_cls = CLS_BRA;
			GRP_B: raw_cls = CLS_BSR;
			GRP_C: raw_cls = CLS_GRPC_BASE + class_t'(mid);
			GRP_D: raw_cls = CLS_MOVL_IMM;
			GRP_E: raw_cls = CLS_MOV_IMM;
			default: raw_cls = CLS_ILLEGAL;
		endcase
	end

	assign cls = (slot && is_slot_illegal(raw_cls)) ? CLS_ILLEGAL_SLOT : raw_cls;

endmodule

// ===== hdl/risc16_instruction_class_decoder.sv =====
// ----------------------------------------------------------------------------
// RISC16 instruction class decoder
// Classifies one 16-bit instruction word per clock into an 8-bit class code.
// ----------------------------------------------------------------------------
// This block takes one instruction transfer in every clock cycle. The word and
// slot flag are captured in an input register at the accepting edge, decoded
// by a short table lookup, and the class is loaded into a result register at
// the next edge. It is held there for the single cycle in which done is high.
// Those two register stages lie between a word and its class; the throughput
// is one transfer per cycle with no gaps. The receiver cannot stall, so busy
// is never asserted and each result must be taken in the cycle it appears.
// Class 0 means an unlisted encoding, class 1 means a branch, jump, return or
// TRAPA found in a delay slot, and 2 through 143 name the instruction kinds.
// The block holds no state besides its two pipeline stages.
module risc16_instruction_class_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  r16icd_pkg::word_t  instruction_word,
	input  logic               in_delay_slot,
	output logic               done,
	output r16icd_pkg::class_t instruction_class
);
	import r16icd_pkg::*;

	logic   accept;
	logic   valid_s1;
	word_t  word_s1;
	logic   slot_s1;
	class_t cls_dec;
	logic   valid_s2;
	class_t cls_s2;

	// The pipeline never backs up, so a transfer is taken whenever start is high.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= instruction_word;
			slot_s1 <= in_delay_slot;
		end
	end

	// Decode between the two registers.
	r16icd_decode u_decode (
		.word (word_s1),
		.slot (slot_s1),
		.cls  (cls_dec)
	);

	// Stage 2: result register, shown for exactly one cycle per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			cls_s2 <= cls_dec;
		end
	end

	assign done              = valid_s2;
	assign instruction_class = cls_s2;

	// Every result comes from a matching accepted input transfer.
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("result without a matching input transfer");

	// Every accepted transfer produces a result.
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		start ##2 1'b1 |-> done)
		else $error("input transfer produced no result");

	// The slot-illegal class only appears for words taken in a delay slot.
	a_slot_class: assert property (@(posedge clk) disable iff (!arst_n)
		done && (instruction_class == CLS_ILLEGAL_SLOT) |-> $past(in_delay_slot, 2))
		else $error("slot-illegal class outside a delay slot");

	// Class codes stay within the defined range.
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (instruction_class <= CLS_MAX))
		else $error("class code out of range");

endmodule
